// ----- hw/rtl/pkrp_pkg.sv -----
// Shared types and constants of the perf kernel symbol record parser.
package pkrp_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_CHAR  = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_ABORT = 2'd3;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RECORD_BYTES   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYMBOL_RECORD_TYPE = 2'd1;
   localparam int CSR_DATA_W = 32;

   localparam logic [15:0] MAX_RECORD_BYTES_RESET   = 16'd1024;
   localparam logic [31:0] SYMBOL_RECORD_TYPE_RESET = 32'd17;

   // Record layout, in byte positions from the start of the record.
   localparam logic [15:0] HEADER_BYTES    = 16'd8;
   localparam logic [15:0] SIZE_LAST_POS   = 16'd7;
   localparam logic [15:0] FLAGS_POS       = 16'd22;
   localparam logic [15:0] START_POS       = 16'd23;
   localparam logic [15:0] NAME_OFFSET     = 16'd24;

   // Name character filter bounds.
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DEL   = 8'h7f;
   localparam logic [7:0] CHAR_COLON = 8'h3a;

   // Result queue geometry.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] sym_address;
      logic [31:0] sym_length;
      logic [15:0] sym_kind;
      logic [7:0]  name_char;
      logic        last;
   } rsp_item_type;

   // Up to two result words produced by one input byte, in order.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

// ----- hw/rtl/pkrp_req_if.sv -----
// Input byte channel of the perf kernel symbol record parser.
interface pkrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       window_end;

   modport source (output valid, output data_byte, output window_end, input ready);
   modport sink (input valid, input data_byte, input window_end, output ready);
endinterface

// ----- hw/rtl/pkrp_rsp_if.sv -----
// Result channel of the perf kernel symbol record parser.
interface pkrp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [63:0] sym_address;
   logic [31:0] sym_length;
   logic [15:0] sym_kind;
   logic [7:0]  name_char;
   logic        last;

   modport source (output valid, output kind, output sym_address, output sym_length,
                   output sym_kind, output name_char, output last, input ready);
   modport sink (input valid, input kind, input sym_address, input sym_length,
                 input sym_kind, input name_char, input last, output ready);
endinterface

// ----- hw/rtl/perf_ksymbol_record_parser.sv -----
// Top level of the streaming parser for perf kernel symbol records.
//
// The req channel carries the record stream one byte per word, little-endian,
// with window_end set on the last byte currently available. The rsp channel
// carries result words: a symbol start with address, length and type, then
// one word per accepted name character, then an end word, or an abort word
// when the window closes in the middle of an open symbol.
// The csr port writes the largest accepted record size and the record type
// that marks a kernel symbol record; the user writes it only while the block
// is idle, which the block does not enforce. A byte is parsed in the cycle it
// is accepted and its results are written to the queue. One byte is accepted
// in every cycle while ready is high; a byte that closes a name with its last
// character yields two words, which leave one at a time. The four-word result
// queue sets the rate: req_if.ready is low while it holds more than two words,
// which happens only when the receiver stalls or two-word bytes pile up.
// Reset clears all parse state, empties the queue and returns both
// configuration registers to their defaults (1024 bytes, type 17).
// When the receiver stalls, words wait in the queue and input stops once the
// queue cannot take the worst case of two more words.
module perf_ksymbol_record_parser #(
   parameter int NAME_MAX_CHARS = 255
) (
   input  logic                                clock,
   input  logic                                reset,
   pkrp_req_if.sink                            req_if,
   pkrp_rsp_if.source                          rsp_if,
   input  logic                                csr_write_enable,
   input  logic [pkrp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [pkrp_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   localparam int NameCntW = $clog2(NAME_MAX_CHARS + 1);

   // Configuration registers.
   logic [15:0] max_record_bytes_ff;
   logic [31:0] symbol_record_type_ff;

   // Parse state of the current record.
   logic [15:0]         byte_position_ff, byte_position_in;
   logic [31:0]         header_type_ff, header_type_in;
   logic [15:0]         header_size_ff, header_size_in;
   logic [63:0]         address_acc_ff, address_acc_in;
   logic [31:0]         length_acc_ff, length_acc_in;
   logic [15:0]         symtype_acc_ff, symtype_acc_in;
   logic                unregister_bit_ff, unregister_bit_in;
   logic                symbol_open_ff, symbol_open_in;
   logic                name_stopped_ff, name_stopped_in;
   logic [NameCntW-1:0] name_count_ff, name_count_in;
   logic                halted_ff, halted_in;

   logic                   accept;
   logic                   space_ok;
   pkrp_pkg::push_type     push;
   pkrp_pkg::rsp_item_type out_item;

   assign req_if.ready = space_ok;
   assign accept       = req_if.valid && space_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_record_bytes_ff   <= pkrp_pkg::MAX_RECORD_BYTES_RESET;
         symbol_record_type_ff <= pkrp_pkg::SYMBOL_RECORD_TYPE_RESET;
      end else if (csr_write_enable) begin
         if (csr_index == pkrp_pkg::CSR_MAX_RECORD_BYTES) begin
            max_record_bytes_ff <= csr_write_data[15:0];
         end else if (csr_index == pkrp_pkg::CSR_SYMBOL_RECORD_TYPE) begin
            symbol_record_type_ff <= csr_write_data;
         end
      end
   end

   // Per-byte parse step. The size check and the end-of-record test use the
   // header size as updated by the current byte, so they see the size byte
   // that arrives in the same word.
   always_comb begin
      logic [7:0]  b;
      logic        we;
      logic [15:0] pos;
      logic [16:0] pos_inc;
      logic        clear_rec;
      logic        bad_size;
      logic        complete;
      logic        start;
      logic        name_ev;
      logic        bad_char;
      logic        emit_char;
      logic        close_ev;
      pkrp_pkg::rsp_item_type start_item;
      pkrp_pkg::rsp_item_type char_item;
      pkrp_pkg::rsp_item_type close_item;

      b       = req_if.data_byte;
      we      = req_if.window_end;
      pos     = byte_position_ff;
      pos_inc = {1'b0, pos} + 17'd1;

      byte_position_in  = byte_position_ff;
      header_type_in    = header_type_ff;
      header_size_in    = header_size_ff;
      address_acc_in    = address_acc_ff;
      length_acc_in     = length_acc_ff;
      symtype_acc_in    = symtype_acc_ff;
      unregister_bit_in = unregister_bit_ff;
      symbol_open_in    = symbol_open_ff;
      name_stopped_in   = name_stopped_ff;
      name_count_in     = name_count_ff;
      halted_in         = halted_ff;

      clear_rec = 1'b0;
      bad_size  = 1'b0;
      complete  = 1'b0;
      start     = 1'b0;
      name_ev   = 1'b0;
      emit_char = 1'b0;
      close_ev  = 1'b0;
      bad_char  = (b <= pkrp_pkg::CHAR_SPACE) || (b >= pkrp_pkg::CHAR_DEL)
                  || (b == pkrp_pkg::CHAR_COLON);
      push      = '0;

      start_item             = '0;
      start_item.kind        = pkrp_pkg::KIND_START;
      start_item.sym_address = address_acc_ff;
      start_item.sym_length  = length_acc_ff;
      start_item.sym_kind    = symtype_acc_ff;
      char_item              = '0;
      char_item.kind         = pkrp_pkg::KIND_CHAR;
      char_item.name_char    = b;
      close_item             = '0;
      close_item.last        = 1'b1;

      if (accept) begin
         if (halted_ff) begin
            // Skip everything up to the next window end.
            if (we) begin
               clear_rec = 1'b1;
               halted_in = 1'b0;
            end
         end else begin
            for (int i = 0; i < 4; i++) begin
               if (pos == 16'(i)) header_type_in[8*i +: 8] = b;
            end
            for (int i = 0; i < 2; i++) begin
               if (pos == 16'(6 + i)) header_size_in[8*i +: 8] = b;
            end
            for (int i = 0; i < 8; i++) begin
               if (pos == 16'(8 + i)) address_acc_in[8*i +: 8] = b;
            end
            for (int i = 0; i < 4; i++) begin
               if (pos == 16'(16 + i)) length_acc_in[8*i +: 8] = b;
            end
            for (int i = 0; i < 2; i++) begin
               if (pos == 16'(20 + i)) symtype_acc_in[8*i +: 8] = b;
            end
            if (pos == pkrp_pkg::FLAGS_POS) unregister_bit_in = b[0];

            bad_size = (pos == pkrp_pkg::SIZE_LAST_POS)
                       && ((header_size_in < pkrp_pkg::HEADER_BYTES)
                           || (header_size_in > max_record_bytes_ff));

            if (bad_size) begin
               clear_rec = 1'b1;
               halted_in = !we;
            end else begin
               complete = (pos >= pkrp_pkg::SIZE_LAST_POS)
                          && (pos_inc == {1'b0, header_size_in});
               start = (pos == pkrp_pkg::START_POS) && !we
                       && (header_type_ff == symbol_record_type_ff)
                       && (header_size_ff > pkrp_pkg::NAME_OFFSET)
                       && !unregister_bit_ff && (address_acc_ff != 64'd0);
               if (start) symbol_open_in = 1'b1;

               name_ev = (pos >= pkrp_pkg::NAME_OFFSET) && symbol_open_ff
                         && !name_stopped_ff && (complete || !we);
               emit_char = name_ev && !bad_char
                           && (name_count_ff < NameCntW'(NAME_MAX_CHARS));
               if (emit_char) begin
                  name_count_in = name_count_ff + NameCntW'(1);
               end else if (name_ev) begin
                  name_stopped_in = 1'b1;
               end

               // A record end or a window cut-off closes an open symbol.
               close_ev = (complete || we) && symbol_open_in;
               close_item.kind = complete ? pkrp_pkg::KIND_END : pkrp_pkg::KIND_ABORT;

               if (complete || we) begin
                  clear_rec = 1'b1;
               end else begin
                  byte_position_in = pos_inc[15:0];
               end

               // Start never shares a byte with a name character or a close.
               priority if (start) begin
                  push.count = 2'd1;
                  push.item0 = start_item;
               end else if (emit_char) begin
                  push.count = close_ev ? 2'd2 : 2'd1;
                  push.item0 = char_item;
                  push.item1 = close_item;
               end else if (close_ev) begin
                  push.count = 2'd1;
                  push.item0 = close_item;
               end else begin
                  push.count = 2'd0;
               end
            end
         end
      end

      if (clear_rec) begin
         byte_position_in  = '0;
         header_type_in    = '0;
         header_size_in    = '0;
         address_acc_in    = '0;
         length_acc_in     = '0;
         symtype_acc_in    = '0;
         unregister_bit_in = 1'b0;
         symbol_open_in    = 1'b0;
         name_stopped_in   = 1'b0;
         name_count_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff  <= '0;
         header_type_ff    <= '0;
         header_size_ff    <= '0;
         address_acc_ff    <= '0;
         length_acc_ff     <= '0;
         symtype_acc_ff    <= '0;
         unregister_bit_ff <= 1'b0;
         symbol_open_ff    <= 1'b0;
         name_stopped_ff   <= 1'b0;
         name_count_ff     <= '0;
         halted_ff         <= 1'b0;
      end else begin
         byte_position_ff  <= byte_position_in;
         header_type_ff    <= header_type_in;
         header_size_ff    <= header_size_in;
         address_acc_ff    <= address_acc_in;
         length_acc_ff     <= length_acc_in;
         symtype_acc_ff    <= symtype_acc_in;
         unregister_bit_ff <= unregister_bit_in;
         symbol_open_ff    <= symbol_open_in;
         name_stopped_ff   <= name_stopped_in;
         name_count_ff     <= name_count_in;
         halted_ff         <= halted_in;
      end
   end

   // The queue holds finished words so parsing continues while rsp stalls.
   pkrp_result_fifo u_result_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .space_ok  (space_ok),
      .out_valid (rsp_if.valid),
      .out_item  (out_item),
      .out_ready (rsp_if.ready)
   );

   assign rsp_if.kind        = out_item.kind;
   assign rsp_if.sym_address = out_item.sym_address;
   assign rsp_if.sym_length  = out_item.sym_length;
   assign rsp_if.sym_kind    = out_item.sym_kind;
   assign rsp_if.name_char   = out_item.name_char;
   assign rsp_if.last        = out_item.last;

endmodule

// ----- hw/rtl/pkrp_result_fifo.sv -----
// Small result queue that takes up to two words per cycle and gives one.
module pkrp_result_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  pkrp_pkg::push_type     push,
   output logic                   space_ok,
   output logic                   out_valid,
   output pkrp_pkg::rsp_item_type out_item,
   input  logic                   out_ready
);

   pkrp_pkg::rsp_item_type mem_ff [pkrp_pkg::FIFO_DEPTH];
   logic [pkrp_pkg::FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pkrp_pkg::FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pkrp_pkg::FIFO_CNT_W-1:0] count_ff, count_in;
   logic                            pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   // Room for the worst case of two words from the next byte.
   assign space_ok  = (count_ff <= pkrp_pkg::FIFO_CNT_W'(pkrp_pkg::FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + pkrp_pkg::FIFO_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + pkrp_pkg::FIFO_PTR_W'(pop);
      count_in  = count_ff + pkrp_pkg::FIFO_CNT_W'(push.count)
                  - pkrp_pkg::FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + pkrp_pkg::FIFO_PTR_W'(1)] <= push.item1;
      end
   end

endmodule

// ----- tb/pkrp_record_checker.sv -----
// Checker for the perf kernel symbol record parser: predicts result words and compares them.
module pkrp_record_checker #(
   parameter int NAME_MAX_CHARS = 255
) (
   input  logic                             clock,
   input  logic                             reset,
   pkrp_req_if                              req_if,
   pkrp_rsp_if                              rsp_if,
   input  logic                             csr_write_enable,
   input  logic [pkrp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pkrp_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int unsigned                      fail_total,
   output int unsigned                      words_pending,
   output int unsigned                      words_checked,
   output int unsigned                      symbols_started
);

   // Register copies.
   logic [15:0] cfg_max_bytes;
   logic [31:0] cfg_record_type;

   // Parse state of the current record.
   logic [15:0] rec_pos;
   logic [31:0] rec_type;
   logic [15:0] rec_size;
   logic [63:0] rec_addr;
   logic [31:0] rec_len;
   logic [15:0] rec_symtype;
   logic        rec_unreg;
   logic        sym_open;
   logic        name_done;
   int unsigned name_chars;
   logic        skipping;

   pkrp_pkg::rsp_item_type pending_words[$];
   int unsigned            fail_count;
   int unsigned            word_index;
   int unsigned            start_count;

   function automatic void clear_record();
      rec_pos     = '0;
      rec_type    = '0;
      rec_size    = '0;
      rec_addr    = '0;
      rec_len     = '0;
      rec_symtype = '0;
      rec_unreg   = 1'b0;
      sym_open    = 1'b0;
      name_done   = 1'b0;
      name_chars  = 0;
   endfunction

   function automatic void push_word(logic [1:0] kind, logic [63:0] addr, logic [31:0] len,
                                     logic [15:0] stype, logic [7:0] ch, logic last);
      pkrp_pkg::rsp_item_type w;
      w.kind        = kind;
      w.sym_address = addr;
      w.sym_length  = len;
      w.sym_kind    = stype;
      w.name_char   = ch;
      w.last        = last;
      pending_words.push_back(w);
   endfunction

   // Advances the record parse by one byte and queues the words it produces.
   function automatic void parse_byte(logic [7:0] b, logic we);
      int unsigned pos;
      logic        whole;
      pos = 32'(rec_pos);
      if (skipping) begin
         if (we) begin
            clear_record();
            skipping = 1'b0;
         end
         return;
      end
      if (pos < 4)
         rec_type[8*pos +: 8] = b;
      else if (pos == 6 || pos == 7)
         rec_size[8*(pos-6) +: 8] = b;
      else if (pos >= 8 && pos < 16)
         rec_addr[8*(pos-8) +: 8] = b;
      else if (pos >= 16 && pos < 20)
         rec_len[8*(pos-16) +: 8] = b;
      else if (pos == 20 || pos == 21)
         rec_symtype[8*(pos-20) +: 8] = b;
      else if (pos == pkrp_pkg::FLAGS_POS)
         rec_unreg = b[0];

      if (pos == pkrp_pkg::SIZE_LAST_POS
          && (rec_size < pkrp_pkg::HEADER_BYTES || rec_size > cfg_max_bytes)) begin
         clear_record();
         skipping = !we;
         return;
      end

      whole = (pos >= pkrp_pkg::SIZE_LAST_POS) && (pos + 1 == rec_size);

      if (pos == pkrp_pkg::START_POS && !we && rec_type == cfg_record_type
          && rec_size > pkrp_pkg::NAME_OFFSET && !rec_unreg && rec_addr != 0) begin
         push_word(pkrp_pkg::KIND_START, rec_addr, rec_len, rec_symtype, 8'h00, 1'b0);
         sym_open = 1'b1;
         start_count++;
      end

      if (pos >= pkrp_pkg::NAME_OFFSET && sym_open && !name_done && (whole || !we)) begin
         if (b <= pkrp_pkg::CHAR_SPACE || b >= pkrp_pkg::CHAR_DEL
             || b == pkrp_pkg::CHAR_COLON) begin
            name_done = 1'b1;
         end else if (name_chars < NAME_MAX_CHARS) begin
            push_word(pkrp_pkg::KIND_CHAR, 64'h0, 32'h0, 16'h0, b, 1'b0);
            name_chars++;
         end else begin
            name_done = 1'b1;
         end
      end

      if (whole) begin
         if (sym_open)
            push_word(pkrp_pkg::KIND_END, 64'h0, 32'h0, 16'h0, 8'h00, 1'b1);
         clear_record();
      end else if (we) begin
         if (sym_open)
            push_word(pkrp_pkg::KIND_ABORT, 64'h0, 32'h0, 16'h0, 8'h00, 1'b1);
         clear_record();
      end else begin
         rec_pos = 16'(pos + 1);
      end
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] result word %0d: %s is %0h, expected %0h",
               $time, word_index, what, got, want);
      fail_count++;
   endtask

   task automatic check_word();
      pkrp_pkg::rsp_item_type w;
      if (pending_words.size() == 0) begin
         report_mismatch("unexpected word, kind", 64'(rsp_if.kind), 64'h0);
      end else begin
         w = pending_words.pop_front();
         if (rsp_if.kind !== w.kind)
            report_mismatch("kind", 64'(rsp_if.kind), 64'(w.kind));
         if (rsp_if.sym_address !== w.sym_address)
            report_mismatch("sym_address", rsp_if.sym_address, w.sym_address);
         if (rsp_if.sym_length !== w.sym_length)
            report_mismatch("sym_length", 64'(rsp_if.sym_length), 64'(w.sym_length));
         if (rsp_if.sym_kind !== w.sym_kind)
            report_mismatch("sym_kind", 64'(rsp_if.sym_kind), 64'(w.sym_kind));
         if (rsp_if.name_char !== w.name_char)
            report_mismatch("name_char", 64'(rsp_if.name_char), 64'(w.name_char));
         if (rsp_if.last !== w.last)
            report_mismatch("last", 64'(rsp_if.last), 64'(w.last));
      end
      word_index++;
   endtask

   initial begin
      fail_count  = 0;
      word_index  = 0;
      start_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         clear_record();
         skipping        = 1'b0;
         cfg_max_bytes   = pkrp_pkg::MAX_RECORD_BYTES_RESET;
         cfg_record_type = pkrp_pkg::SYMBOL_RECORD_TYPE_RESET;
         pending_words.delete();
      end else begin
         // A word leaving now was caused by an earlier byte, so check before predicting.
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            check_word();
         if (csr_write_enable) begin
            case (csr_index)
               pkrp_pkg::CSR_MAX_RECORD_BYTES:   cfg_max_bytes = csr_write_data[15:0];
               pkrp_pkg::CSR_SYMBOL_RECORD_TYPE: cfg_record_type = csr_write_data;
               default: ;
            endcase
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
            parse_byte(req_if.data_byte, req_if.window_end);
      end
      fail_total      <= fail_count;
      words_pending   <= pending_words.size();
      words_checked   <= word_index;
      symbols_started <= start_count;
   end

endmodule

// ----- tb/tb_perf_ksymbol_record_parser.sv -----
// Testbench top for the perf kernel symbol record parser: stimulus, idling and verdict.
module tb_perf_ksymbol_record_parser;

   localparam int NAME_CHARS    = 255;
   localparam int WAIT_MAX      = 19;
   localparam int RANDOM_ITEMS  = 200;
   localparam int RANDOM_PHASES = 4;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 20;
   localparam int IDLE_LIMIT    = 2000;

   // Indexes past the last register; writes to them must change nothing.
   localparam logic [pkrp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [pkrp_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [pkrp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pkrp_pkg::CSR_DATA_W-1:0]  csr_write_data;

   pkrp_req_if req_if ();
   pkrp_rsp_if rsp_if ();

   int unsigned fail_total;
   int unsigned words_pending;
   int unsigned words_checked;
   int unsigned symbols_started;

   perf_ksymbol_record_parser #(
      .NAME_MAX_CHARS(NAME_CHARS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   pkrp_record_checker #(
      .NAME_MAX_CHARS(NAME_CHARS)
   ) record_check (
      .clock           (clock),
      .reset           (reset),
      .req_if          (req_if),
      .rsp_if          (rsp_if),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .fail_total      (fail_total),
      .words_pending   (words_pending),
      .words_checked   (words_checked),
      .symbols_started (symbols_started)
   );

   // Our own view of the register settings, used only to shape records so that
   // most of them pass the type and size checks.
   int          cur_max;
   logic [31:0] cur_type;

   // Bytes of the window being assembled; the last one carries window_end.
   logic [7:0]  stream_q[$];

   int unsigned items_sent;
   int unsigned windows_sent;
   int unsigned settings_used;
   int          send_mode;
   int unsigned idle_cycles;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The watchdog counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Watchdog: no word moved for %0d cycles, %0d results still expected",
               IDLE_LIMIT, words_pending);
      $display("Simulation FAILED");
      $finish;
   end

   // Wait length for one word. Mode 0 never idles, mode 1 may idle on every word and
   // mode 2 idles now and then, so the run has both dense bursts and scattered gaps.
   function automatic int draw_wait(int mode);
      case (mode)
         0:       return 0;
         1:       return $urandom_range(0, WAIT_MAX);
         default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, WAIT_MAX) : 0;
      endcase
   endfunction

   // The receiver holds ready low for a random number of cycles before each word.
   initial begin : result_sink
      int stall;
      int taken;
      int mode;
      taken = 0;
      mode  = 0;
      wait (reset == 1'b0);
      forever begin
         if (taken % 64 == 0)
            mode = $urandom_range(0, 2);
         stall = draw_wait(mode);
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         taken++;
      end
   end

   // Sends one byte. Valid stays high straight into the next byte when no gap is
   // drawn; it is only lowered at the first falling edge of a gap.
   task automatic send_byte(logic [7:0] b, logic we);
      int gap;
      if (items_sent % 64 == 0)
         send_mode = $urandom_range(0, 2);
      gap = draw_wait(send_mode);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid      <= 1'b1;
      req_if.data_byte  <= b;
      req_if.window_end <= we;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      items_sent++;
   endtask

   task automatic send_window();
      int k;
      for (k = 0; k < stream_q.size(); k++)
         send_byte(stream_q[k], k == stream_q.size() - 1);
      stream_q.delete();
      windows_sent++;
   endtask

   // Stops the input and holds until every expected result word has been taken,
   // then lets the parser settle, since a byte may leave no word.
   task automatic drain_results();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (words_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [pkrp_pkg::CSR_INDEX_W-1:0] index,
                            logic [pkrp_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // The size register only keeps its low half; the upper bits get random junk.
   task automatic set_config(int max_bytes, logic [31:0] rec_type);
      drain_results();
      write_csr(pkrp_pkg::CSR_MAX_RECORD_BYTES, {16'($urandom), 16'(max_bytes)});
      write_csr(pkrp_pkg::CSR_SYMBOL_RECORD_TYPE, rec_type);
      cur_max  = max_bytes;
      cur_type = rec_type;
      settings_used++;
   endtask

   function automatic logic [7:0] printable_char();
      logic [7:0] c;
      do c = 8'($urandom_range(pkrp_pkg::CHAR_SPACE + 1, pkrp_pkg::CHAR_DEL - 1));
      while (c == pkrp_pkg::CHAR_COLON);
      return c;
   endfunction

   // One character from a random one of the classes that end a name.
   function automatic logic [7:0] pick_stop();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'($urandom_range(1, pkrp_pkg::CHAR_SPACE));
         2:       return 8'($urandom_range(pkrp_pkg::CHAR_DEL, 255));
         default: return pkrp_pkg::CHAR_COLON;
      endcase
   endfunction

   // Appends one record to the window. The header claims hdr_size bytes but only
   // emit bytes go out, which is how cut-off and bad-size records are built.
   // The name holds name_len printable characters, then the stop character, then
   // random filler up to the end of the record.
   task automatic add_record(logic [31:0] rtype, int hdr_size, int emit, logic [63:0] addr,
                             logic [31:0] len, logic [15:0] stype, logic [15:0] flags,
                             int name_len, logic [7:0] stop);
      logic [15:0] hdr;
      logic [7:0]  v;
      int          k;
      hdr = 16'(hdr_size);
      for (k = 0; k < emit; k++) begin
         if (k < 4)
            v = rtype[8*k +: 8];
         else if (k < 6)
            v = 8'($urandom_range(0, 255));
         else if (k < 8)
            v = hdr[8*(k-6) +: 8];
         else if (k < 16)
            v = addr[8*(k-8) +: 8];
         else if (k < 20)
            v = len[8*(k-16) +: 8];
         else if (k < 22)
            v = stype[8*(k-20) +: 8];
         else if (k < 24)
            v = flags[8*(k-22) +: 8];
         else if (k - 24 < name_len)
            v = printable_char();
         else if (k - 24 == name_len)
            v = stop;
         else
            v = 8'($urandom_range(0, 255));
         stream_q.push_back(v);
      end
   endtask

   // Most sizes are short names; a few are long enough to hit the name limit.
   function automatic int pick_size();
      int r;
      int top_small;
      int top_big;
      r = $urandom_range(0, 99);
      if (cur_max < 25 || r < 10) begin
         top_small = (cur_max < 24) ? cur_max : 24;
         return $urandom_range(8, top_small);
      end
      top_big = (r < 92) ? 48 : 324;
      if (top_big > cur_max)
         top_big = cur_max;
      return $urandom_range(25, top_big);
   endfunction

   function automatic int bad_size();
      if (cur_max < 65535 && $urandom_range(0, 1) == 1)
         return $urandom_range(cur_max + 1, 65535);
      return $urandom_range(0, 7);
   endfunction

   // A random window: mostly one to three well-formed records with random
   // content, where the last may be cut off or carry a bad size, and now and
   // then a burst of plain noise.
   task automatic random_window();
      int          nrec;
      int          i;
      int          r;
      int          size;
      int          emit;
      int          name_len;
      logic [31:0] rtype;
      logic [63:0] addr;
      logic [15:0] flags;
      if ($urandom_range(0, 99) < 8) begin
         repeat ($urandom_range(1, 24)) stream_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         nrec = $urandom_range(1, 3);
         for (i = 0; i < nrec; i++) begin
            rtype = ($urandom_range(0, 99) < 85) ? cur_type : $urandom;
            addr  = ($urandom_range(0, 19) == 0) ? 64'h0 : {$urandom, $urandom};
            flags = 16'($urandom);
            if ($urandom_range(0, 9) != 0)
               flags[0] = 1'b0;
            size     = pick_size();
            name_len = $urandom_range(0, (size > 24) ? size - 22 : 0);
            emit     = size;
            if (i == nrec - 1) begin
               r = $urandom_range(0, 99);
               if (r < 15) begin
                  emit = $urandom_range(1, size - 1);
               end else if (r < 23) begin
                  size = bad_size();
                  emit = ($urandom_range(0, 9) == 0) ? 8 : 8 + $urandom_range(1, 12);
               end
            end
            add_record(rtype, size, emit, addr, $urandom, 16'($urandom), flags, name_len,
                       pick_stop());
         end
      end
      send_window();
   endtask

   initial begin : stimulus
      logic [7:0]  stops[7];
      int          i;
      int          p;
      int unsigned budget_end;

      stops = '{8'h00, 8'h1f, pkrp_pkg::CHAR_SPACE, pkrp_pkg::CHAR_DEL, 8'h80, 8'hff,
                pkrp_pkg::CHAR_COLON};
      clock             = 1'b0;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.data_byte  = 8'h00;
      req_if.window_end = 1'b0;
      rsp_if.ready      = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = pkrp_pkg::CSR_MAX_RECORD_BYTES;
      csr_write_data    = '0;
      cur_max           = int'(pkrp_pkg::MAX_RECORD_BYTES_RESET);
      cur_type          = pkrp_pkg::SYMBOL_RECORD_TYPE_RESET;
      items_sent        = 0;
      windows_sent      = 0;
      settings_used     = 1;
      send_mode         = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, reset settings first. A symbol with all-ones fields whose
      // name stops at a NUL, with the window closing on the record's last byte.
      add_record(cur_type, 30, 30, '1, '1, '1, 16'h0000, 3, 8'h00);
      send_window();

      // One record per kind of stop character, then a name that runs right up to
      // the end of the record, so its last byte gives a character and the end word.
      for (i = 0; i < 7; i++)
         add_record(cur_type, 26, 26, 64'h1, 32'h0, 16'h1, 16'hfffe, 1, stops[i]);
      add_record(cur_type, 27, 27, 64'h8000_0000_0000_0000, 32'h1234, 16'h2, 16'h0, 3, 8'h00);
      send_window();

      // Records that must be passed over silently: another type, a size of exactly
      // 24, the unregister flag set and a zero address. Then the shortest symbol.
      add_record(cur_type + 1, 30, 30, 64'h10, 32'h20, 16'h1, 16'h0, 6, 8'h00);
      add_record(cur_type, 24, 24, 64'h10, 32'h20, 16'h1, 16'h0, 0, 8'h00);
      add_record(cur_type, 30, 30, 64'h10, 32'h20, 16'h1, 16'h0001, 6, 8'h00);
      add_record(cur_type, 30, 30, 64'h0, 32'h20, 16'h1, 16'h0, 6, 8'h00);
      add_record(cur_type, 25, 25, 64'h10, 32'h20, 16'h1, 16'h0, 1, 8'h00);
      send_window();

      // Bad header sizes halt the parser until the window ends: below eight, zero
      // and one past the largest size. A good record after them proves the restart.
      add_record(cur_type, 7, 15, 64'h10, 32'h20, 16'h1, 16'h0, 4, 8'h00);
      send_window();
      add_record(cur_type, 0, 9, 64'h10, 32'h20, 16'h1, 16'h0, 4, 8'h00);
      send_window();
      add_record(cur_type, cur_max + 1, 20, 64'h10, 32'h20, 16'h1, 16'h0, 4, 8'h00);
      send_window();
      add_record(cur_type, 30, 30, 64'h55, 32'h66, 16'h1, 16'h0, 6, 8'h00);
      send_window();

      // A bad size whose size byte also closes the window does not halt.
      add_record(cur_type, 3, 8, 64'h10, 32'h20, 16'h1, 16'h0, 4, 8'h00);
      send_window();
      add_record(cur_type, 30, 30, 64'h77, 32'h88, 16'h2, 16'h0, 6, 8'h00);
      send_window();

      // Window cut-offs: inside the header, on the start byte, inside a running
      // name and after the name has already stopped.
      add_record(cur_type, 30, 30, 64'h99, 32'h1, 16'h1, 16'h0, 6, 8'h00);
      add_record(cur_type, 30, 4, 64'h99, 32'h1, 16'h1, 16'h0, 6, 8'h00);
      send_window();
      add_record(cur_type, 40, 24, 64'h99, 32'h1, 16'h1, 16'h0, 16, 8'h00);
      send_window();
      add_record(cur_type, 40, 30, 64'h99, 32'h1, 16'h1, 16'h0, 16, 8'h00);
      send_window();
      add_record(cur_type, 40, 35, 64'h99, 32'h1, 16'h1, 16'h0, 2, pkrp_pkg::CHAR_COLON);
      send_window();

      // A name longer than the character limit: the rest is consumed silently.
      add_record(cur_type, 290, 290, 64'habc, 32'h40, 16'h1, 16'h0, 270, 8'h00);
      send_window();

      // Writes to the unused indexes must leave both registers as they are.
      drain_results();
      write_csr(CSR_SPARE_LOW, $urandom);
      write_csr(CSR_SPARE_HIGH, $urandom);
      add_record(cur_type, 30, 30, 64'h1234, 32'h5, 16'h1, 16'h0, 6, 8'h00);
      send_window();

      // Smallest size limit and type zero: a header-only record, then one byte too
      // many in the size field.
      set_config(8, 32'h0);
      add_record(cur_type, 8, 8, 64'h0, 32'h0, 16'h0, 16'h0, 0, 8'h00);
      send_window();
      add_record(cur_type, 9, 12, 64'h0, 32'h0, 16'h0, 16'h0, 0, 8'h00);
      send_window();

      // Largest size limit and all-ones type: a maximal record cut off inside its
      // name, and a record of the old default type that must be ignored.
      set_config(65535, 32'hffff_ffff);
      add_record(cur_type, 65535, 40, 64'hfeed, 32'h9, 16'h2, 16'h0, 1000, 8'h00);
      send_window();
      add_record(pkrp_pkg::SYMBOL_RECORD_TYPE_RESET, 30, 30, 64'h10, 32'h1, 16'h1, 16'h0, 6,
                 8'h00);
      send_window();

      // Random part, split over several register settings.
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: set_config(int'(pkrp_pkg::MAX_RECORD_BYTES_RESET),
                          pkrp_pkg::SYMBOL_RECORD_TYPE_RESET);
            1: set_config($urandom_range(25, 400), $urandom);
            2: set_config(65535, 32'hffff_ffff);
            default: set_config($urandom_range(8, 40), $urandom_range(0, 3));
         endcase
         budget_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
         while (items_sent < budget_end)
            random_window();
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d windows under %0d register settings.",
               items_sent, windows_sent, settings_used);
      $display("Checked %0d result words from %0d started symbols, %0d mismatches.",
               words_checked, symbols_started, fail_total);
      if (fail_total == 0 && words_pending == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
